### sv/mppt_perturb_observe_duty_macros.svh
`ifndef MPPT_PERTURB_OBSERVE_DUTY_MACROS_SVH
`define MPPT_PERTURB_OBSERVE_DUTY_MACROS_SVH

// same-cycle implication, checked outside reset
`define MPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mppt_pod_pkg.sv
package mppt_pod_pkg;

  localparam int DUTY_W     = 13;
  localparam int STEP_W     = 10;
  localparam int ADC_W      = 12;
  localparam int WIN_W      = 11;
  localparam int SUM_W      = 20;
  localparam int TICK_W     = 8;
  localparam int POW_W      = 2 * ADC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int WINDOW_TICKS = 200;

  // exact sum / WINDOW_TICKS as (sum * DIV_MULT) >> DIV_SHIFT for any sum below 2**SUM_W
  localparam int DIV_SHIFT           = SUM_W + $clog2(WINDOW_TICKS);
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + WINDOW_TICKS - 1) / WINDOW_TICKS;
  localparam int DIV_MULT_W          = SUM_W + 1;
  localparam int PROD_W              = SUM_W + DIV_MULT_W;

  localparam logic [DUTY_W-1:0] RST_DUTY_MAX      = 13'd4800;
  localparam logic [STEP_W-1:0] RST_MPPT_STEP     = 10'd50;
  localparam logic [ADC_W-1:0]  RST_OV_LIMIT      = 12'd3100;
  localparam logic [STEP_W-1:0] RST_OV_STEP       = 10'd10;
  localparam logic [ADC_W-1:0]  RST_MIN_INPUT     = 12'd50;
  localparam logic [WIN_W-1:0]  RST_TRACK_WINDOWS = 11'd1000;
  localparam logic [WIN_W-1:0]  RST_PERIOD_WINDOWS = 11'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_MAX       = 3'd0,
    CFG_MPPT_STEP      = 3'd1,
    CFG_OV_LIMIT       = 3'd2,
    CFG_OV_STEP        = 3'd3,
    CFG_MIN_INPUT      = 3'd4,
    CFG_TRACK_WINDOWS  = 3'd5,
    CFG_PERIOD_WINDOWS = 3'd6
  } cfg_idx_t;

  typedef logic signed [DUTY_W+1:0] duty_ext_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_max;
    logic [STEP_W-1:0] mppt_step;
    logic [ADC_W-1:0]  ov_limit;
    logic [STEP_W-1:0] ov_step;
    logic [ADC_W-1:0]  min_input;
    logic [WIN_W-1:0]  track_windows;
    logic [WIN_W-1:0]  period_windows;
  } cfg_regs_t;

  typedef struct packed {
    logic              start;
    logic              take;
    logic [SUM_W-1:0]  v_sum;
    logic [SUM_W-1:0]  i_sum;
    logic [DUTY_W-1:0] duty;
  } trk_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DUTY_W-1:0] duty;
  } trk_rsp_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(duty_ext_t d, logic [DUTY_W-1:0] dmax);
    logic [DUTY_W-1:0] r;
    if (d < 0) begin
      r = '0;
    end else if (d > duty_ext_t'(dmax)) begin
      r = dmax;
    end else begin
      r = d[DUTY_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/mppt_pod_if.sv
interface mppt_pod_in_if;
  logic                           valid;
  logic                           ready;
  logic                           emergency;
  logic [mppt_pod_pkg::ADC_W-1:0] out_voltage;
  logic [mppt_pod_pkg::ADC_W-1:0] in_voltage;
  logic [mppt_pod_pkg::ADC_W-1:0] in_current;

  modport source (output valid, emergency, out_voltage, in_voltage, in_current,
                  input ready);
  modport sink (input valid, emergency, out_voltage, in_voltage, in_current,
                output ready);
endinterface

interface mppt_pod_out_if;
  logic                            valid;
  logic                            ready;
  logic [mppt_pod_pkg::DUTY_W-1:0] duty;
  logic                            enable_out;
  logic                            tracked;
  logic                            overvoltage;

  modport source (output valid, duty, enable_out, tracked, overvoltage, input ready);
  modport sink (input valid, duty, enable_out, tracked, overvoltage, output ready);
endinterface

### sv/mppt_pod_cfg.sv
module mppt_pod_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mppt_pod_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mppt_pod_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mppt_pod_pkg::cfg_regs_t              cfg
);

  mppt_pod_pkg::cfg_regs_t regs_r;
  mppt_pod_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        mppt_pod_pkg::CFG_DUTY_MAX: begin
          regs_nxt.duty_max = cfg_wdata[mppt_pod_pkg::DUTY_W-1:0];
        end
        mppt_pod_pkg::CFG_MPPT_STEP: begin
          regs_nxt.mppt_step = cfg_wdata[mppt_pod_pkg::STEP_W-1:0];
        end
        mppt_pod_pkg::CFG_OV_LIMIT: begin
          regs_nxt.ov_limit = cfg_wdata[mppt_pod_pkg::ADC_W-1:0];
        end
        mppt_pod_pkg::CFG_OV_STEP: begin
          regs_nxt.ov_step = cfg_wdata[mppt_pod_pkg::STEP_W-1:0];
        end
        mppt_pod_pkg::CFG_MIN_INPUT: begin
          regs_nxt.min_input = cfg_wdata[mppt_pod_pkg::ADC_W-1:0];
        end
        mppt_pod_pkg::CFG_TRACK_WINDOWS: begin
          regs_nxt.track_windows = cfg_wdata[mppt_pod_pkg::WIN_W-1:0];
        end
        mppt_pod_pkg::CFG_PERIOD_WINDOWS: begin
          regs_nxt.period_windows = cfg_wdata[mppt_pod_pkg::WIN_W-1:0];
        end
        default: begin
          regs_nxt = regs_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.duty_max       <= mppt_pod_pkg::RST_DUTY_MAX;
      regs_r.mppt_step      <= mppt_pod_pkg::RST_MPPT_STEP;
      regs_r.ov_limit       <= mppt_pod_pkg::RST_OV_LIMIT;
      regs_r.ov_step        <= mppt_pod_pkg::RST_OV_STEP;
      regs_r.min_input      <= mppt_pod_pkg::RST_MIN_INPUT;
      regs_r.track_windows  <= mppt_pod_pkg::RST_TRACK_WINDOWS;
      regs_r.period_windows <= mppt_pod_pkg::RST_PERIOD_WINDOWS;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

### sv/mppt_pod_trk.sv
module mppt_pod_trk (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mppt_pod_pkg::trk_req_t  req,
  input  mppt_pod_pkg::cfg_regs_t cfg,
  output mppt_pod_pkg::trk_rsp_t  rsp
);

  logic s1_r, s2_r, s3_r;
  logic [mppt_pod_pkg::SUM_W-1:0]  vsum_r, isum_r;
  logic [mppt_pod_pkg::DUTY_W-1:0] base_r;
  logic [mppt_pod_pkg::ADC_W-1:0]  vavg_r, iavg_r;
  logic [mppt_pod_pkg::POW_W-1:0]  pnew_r;
  logic [mppt_pod_pkg::DUTY_W-1:0] last_step_r;
  logic [mppt_pod_pkg::POW_W-1:0]  last_pow_r;

  logic [mppt_pod_pkg::PROD_W-1:0] vprod, iprod;
  logic [mppt_pod_pkg::POW_W-1:0]  pnew;
  logic                            went_down, go_up;
  mppt_pod_pkg::duty_ext_t         stepped;
  logic [mppt_pod_pkg::DUTY_W-1:0] duty_new;

  // stage 1: window averages by reciprocal multiply
  assign vprod = mppt_pod_pkg::PROD_W'(vsum_r) * mppt_pod_pkg::PROD_W'(mppt_pod_pkg::DIV_MULT);
  assign iprod = mppt_pod_pkg::PROD_W'(isum_r) * mppt_pod_pkg::PROD_W'(mppt_pod_pkg::DIV_MULT);

  // stage 2: power of this window
  assign pnew = mppt_pod_pkg::POW_W'(vavg_r) * mppt_pod_pkg::POW_W'(iavg_r);

  // stage 3: perturb and observe decision
  always_comb begin
    went_down = last_step_r > base_r;
    go_up     = (pnew_r >= last_pow_r) ? !went_down : went_down;
    if (go_up) begin
      stepped = mppt_pod_pkg::duty_ext_t'(base_r) + mppt_pod_pkg::duty_ext_t'(cfg.mppt_step);
    end else begin
      stepped = mppt_pod_pkg::duty_ext_t'(base_r) - mppt_pod_pkg::duty_ext_t'(cfg.mppt_step);
    end
    if (vavg_r < cfg.min_input) begin
      stepped = '0;
    end
    duty_new = mppt_pod_pkg::clamp_duty(stepped, cfg.duty_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      s3_r        <= 1'b0;
      last_step_r <= '0;
      last_pow_r  <= '0;
    end else begin
      s1_r <= req.start;
      s2_r <= s1_r;
      s3_r <= s2_r | (s3_r & !req.take);
      if (s3_r && req.take) begin
        last_step_r <= duty_new;
        last_pow_r  <= pnew_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      vsum_r <= req.v_sum;
      isum_r <= req.i_sum;
      base_r <= req.duty;
    end
    if (s1_r) begin
      vavg_r <= vprod[mppt_pod_pkg::DIV_SHIFT +: mppt_pod_pkg::ADC_W];
      iavg_r <= iprod[mppt_pod_pkg::DIV_SHIFT +: mppt_pod_pkg::ADC_W];
    end
    if (s2_r) begin
      pnew_r <= pnew;
    end
  end

  assign rsp.busy = s1_r | s2_r | s3_r;
  assign rsp.done = s3_r;
  assign rsp.duty = duty_new;

endmodule

### sv/mppt_perturb_observe_duty.sv
// latency: a tick's result is valid in the cycle after the tick is accepted
// a tick that ends a window and takes a tracking step: result goes through the
//   average-divide, power-multiply and decision stages, input held off meanwhile
// throughput: one tick per cycle otherwise, while the output is empty or taken
// reset: rst_n synchronous active low, restores register defaults, zeroes the
//   control state and clears the emergency halt, which nothing else clears
`include "mppt_perturb_observe_duty_macros.svh"

module mppt_perturb_observe_duty (
  input  logic                                clk,
  input  logic                                rst_n,
  mppt_pod_in_if.sink                         in_ch,
  mppt_pod_out_if.source                      out_ch,
  input  logic                                cfg_we,
  input  logic [mppt_pod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mppt_pod_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mppt_pod_pkg::cfg_regs_t cfg;
  mppt_pod_pkg::trk_req_t  trk_req;
  mppt_pod_pkg::trk_rsp_t  trk_rsp;

  logic [mppt_pod_pkg::DUTY_W-1:0] duty_r, duty_nxt;
  logic                            pend_r, pend_nxt;
  logic                            halted_r, halted_nxt;
  logic [mppt_pod_pkg::SUM_W-1:0]  vsum_r, vsum_nxt;
  logic [mppt_pod_pkg::SUM_W-1:0]  isum_r, isum_nxt;
  logic [mppt_pod_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [mppt_pod_pkg::WIN_W-1:0]  win_r, win_nxt;
  logic                            ov_hold_r, ov_hold_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [mppt_pod_pkg::DUTY_W-1:0] out_duty_r;
  logic                            out_en_r, out_trk_r, out_ov_r;

  logic                            in_fire, out_free, out_load, ov;
  logic [mppt_pod_pkg::DUTY_W-1:0] res_duty, duty_ov;
  logic                            res_en, res_trk, res_ov;
  logic [mppt_pod_pkg::SUM_W:0]    vsum_w, isum_w;
  logic [mppt_pod_pkg::TICK_W-1:0] tick_inc;
  logic [mppt_pod_pkg::WIN_W-1:0]  win_inc;
  logic                            win_end, wrap;
  mppt_pod_pkg::duty_ext_t         duty_dec;

  mppt_pod_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mppt_pod_trk u_trk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (trk_req),
    .cfg   (cfg),
    .rsp   (trk_rsp)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !trk_rsp.busy && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    ov = in_ch.out_voltage > cfg.ov_limit;

    // overvoltage on two ticks in a row steps the duty down
    if (ov && pend_r) begin
      duty_dec = mppt_pod_pkg::duty_ext_t'(duty_r) - mppt_pod_pkg::duty_ext_t'(cfg.ov_step);
    end else begin
      duty_dec = mppt_pod_pkg::duty_ext_t'(duty_r);
    end
    duty_ov = mppt_pod_pkg::clamp_duty(duty_dec, cfg.duty_max);

    vsum_w   = {1'b0, vsum_r} + (mppt_pod_pkg::SUM_W+1)'(in_ch.in_voltage);
    isum_w   = {1'b0, isum_r} + (mppt_pod_pkg::SUM_W+1)'(in_ch.in_current);
    tick_inc = tick_r + 1'b1;
    win_end  = tick_inc >= mppt_pod_pkg::TICK_W'(mppt_pod_pkg::WINDOW_TICKS);
    win_inc  = win_r + 1'b1;
    wrap     = win_inc >= cfg.period_windows;
  end

  always_comb begin
    duty_nxt    = duty_r;
    pend_nxt    = pend_r;
    halted_nxt  = halted_r;
    vsum_nxt    = vsum_r;
    isum_nxt    = isum_r;
    tick_nxt    = tick_r;
    win_nxt     = win_r;
    ov_hold_nxt = ov_hold_r;
    out_load    = 1'b0;
    res_duty    = '0;
    res_en      = 1'b0;
    res_trk     = 1'b0;
    res_ov      = 1'b0;
    trk_req.start = 1'b0;
    trk_req.take  = out_free;
    trk_req.v_sum = vsum_w[mppt_pod_pkg::SUM_W] ? '1 : vsum_w[mppt_pod_pkg::SUM_W-1:0];
    trk_req.i_sum = isum_w[mppt_pod_pkg::SUM_W] ? '1 : isum_w[mppt_pod_pkg::SUM_W-1:0];
    trk_req.duty  = duty_ov;

    if (in_fire) begin
      if (halted_r) begin
        out_load = 1'b1;
      end else if (in_ch.emergency) begin
        duty_nxt   = '0;
        halted_nxt = 1'b1;
        out_load   = 1'b1;
        res_ov     = ov;
      end else begin
        pend_nxt = ov;
        duty_nxt = duty_ov;
        if (win_end) begin
          vsum_nxt = '0;
          isum_nxt = '0;
          tick_nxt = '0;
          win_nxt  = wrap ? '0 : win_inc;
        end else begin
          vsum_nxt = trk_req.v_sum;
          isum_nxt = trk_req.i_sum;
          tick_nxt = tick_inc;
        end
        if (win_end && !wrap && (win_inc < cfg.track_windows)) begin
          // result waits for the tracking step
          trk_req.start = 1'b1;
          ov_hold_nxt   = ov;
        end else begin
          out_load = 1'b1;
          res_duty = duty_ov;
          res_en   = 1'b1;
          res_ov   = ov;
        end
      end
    end

    if (trk_rsp.done && out_free) begin
      duty_nxt = trk_rsp.duty;
      out_load = 1'b1;
      res_duty = trk_rsp.duty;
      res_en   = 1'b1;
      res_trk  = 1'b1;
      res_ov   = ov_hold_r;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      pend_r      <= 1'b0;
      halted_r    <= 1'b0;
      vsum_r      <= '0;
      isum_r      <= '0;
      tick_r      <= '0;
      win_r       <= '0;
      ov_hold_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      duty_r      <= duty_nxt;
      pend_r      <= pend_nxt;
      halted_r    <= halted_nxt;
      vsum_r      <= vsum_nxt;
      isum_r      <= isum_nxt;
      tick_r      <= tick_nxt;
      win_r       <= win_nxt;
      ov_hold_r   <= ov_hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_duty_r <= res_duty;
      out_en_r   <= res_en;
      out_trk_r  <= res_trk;
      out_ov_r   <= res_ov;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.duty        = out_duty_r;
  assign out_ch.enable_out  = out_en_r;
  assign out_ch.tracked     = out_trk_r;
  assign out_ch.overvoltage = out_ov_r;

  `MPD_ASSERT_IMP(a_busy_blocks_input, clk, rst_n, trk_rsp.busy, !in_ch.ready,
                  "input accepted while tracking step in flight")
  `MPD_ASSERT_IMP(a_disabled_zero, clk, rst_n, out_ch.valid && !out_ch.enable_out,
                  (out_ch.duty == '0) && !out_ch.tracked,
                  "disabled result carries duty or tracking flag")
  `MPD_ASSERT_NXT(a_halt_sticks, clk, rst_n, halted_r, halted_r,
                  "halt cleared without reset")
  `MPD_ASSERT_IMP(a_duty_clamped, clk, rst_n, out_ch.valid && out_ch.enable_out,
                  out_ch.duty <= cfg.duty_max,
                  "result duty above upper clamp")

endmodule

### dv/duty_tick_checker.sv
`timescale 1ns / 100ps

module duty_tick_checker
  import mppt_pod_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mppt_pod_in_if               in_ch,
  mppt_pod_out_if              out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                   fail_cnt,
  output int                   pending_cnt
);

  localparam int unsigned SUM_CAP = (1 << SUM_W) - 1;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              enable_out;
    logic              tracked;
    logic              overvoltage;
  } duty_result_t;

  duty_result_t duty_results_q[$];

  cfg_regs_t         cfg;
  int                duty_acc;
  int                last_step_duty;
  logic [ADC_W-1:0]  last_v_avg;
  logic [ADC_W-1:0]  last_i_avg;
  logic              ov_armed;
  logic              stopped;
  int unsigned       v_sum;
  int unsigned       i_sum;
  logic [TICK_W-1:0] ticks;
  logic [WIN_W-1:0]  windows;
  int                errors;
  int                n_results;

  initial begin
    errors      = 0;
    n_results   = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] duty check: %s", $time, what);
  endtask

  function automatic void restore_defaults();
    cfg = '{duty_max: RST_DUTY_MAX, mppt_step: RST_MPPT_STEP, ov_limit: RST_OV_LIMIT,
            ov_step: RST_OV_STEP, min_input: RST_MIN_INPUT,
            track_windows: RST_TRACK_WINDOWS, period_windows: RST_PERIOD_WINDOWS};
    duty_acc       = 0;
    last_step_duty = 0;
    last_v_avg     = '0;
    last_i_avg     = '0;
    ov_armed       = 1'b0;
    stopped        = 1'b0;
    v_sum          = 0;
    i_sum          = 0;
    ticks          = '0;
    windows        = '0;
  endfunction

  function automatic int clip_duty(input int d);
    int r;
    r = d;
    if (r > int'(cfg.duty_max)) r = int'(cfg.duty_max);
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic int unsigned sat_sum(input int unsigned s, input logic [ADC_W-1:0] v);
    int unsigned t;
    t = s + v;
    return (t > SUM_CAP) ? SUM_CAP : t;
  endfunction

  // one perturb and observe step on the window averages
  function automatic void perturb(input logic [ADC_W-1:0] v, input logic [ADC_W-1:0] i);
    int unsigned p_now;
    int unsigned p_prev;
    logic        fell;
    logic        climb;
    p_now  = 32'(v) * 32'(i);
    p_prev = 32'(last_v_avg) * 32'(last_i_avg);
    fell   = last_step_duty > duty_acc;
    climb  = (p_now >= p_prev) ? !fell : fell;
    duty_acc = climb ? duty_acc + int'(cfg.mppt_step) : duty_acc - int'(cfg.mppt_step);
    if (v < cfg.min_input) duty_acc = 0;
    duty_acc       = clip_duty(duty_acc);
    last_step_duty = duty_acc;
    last_v_avg     = v;
    last_i_avg     = i;
  endfunction

  function automatic void predict_tick(input logic emerg, input logic [ADC_W-1:0] vo,
                                       input logic [ADC_W-1:0] vi,
                                       input logic [ADC_W-1:0] ii,
                                       output duty_result_t r);
    logic             ov;
    logic             stepped;
    logic [ADC_W-1:0] v_avg;
    logic [ADC_W-1:0] i_avg;
    ov      = vo > cfg.ov_limit;
    stepped = 1'b0;
    r       = '0;
    if (stopped) return;
    if (emerg) begin
      duty_acc      = 0;
      stopped       = 1'b1;
      r.overvoltage = ov;
      return;
    end
    // an overvoltage tick pulls the duty down only if the tick before it was overvoltage too
    if (ov) begin
      if (ov_armed) duty_acc -= int'(cfg.ov_step);
      else ov_armed = 1'b1;
    end else begin
      ov_armed = 1'b0;
    end
    duty_acc = clip_duty(duty_acc);
    v_sum = sat_sum(v_sum, vi);
    i_sum = sat_sum(i_sum, ii);
    ticks = ticks + 1'b1;
    if (ticks >= WINDOW_TICKS) begin
      v_avg   = ADC_W'(v_sum / WINDOW_TICKS);
      i_avg   = ADC_W'(i_sum / WINDOW_TICKS);
      ticks   = '0;
      v_sum   = 0;
      i_sum   = 0;
      windows = windows + 1'b1;
      if (windows >= cfg.period_windows) begin
        windows = '0;
      end else if (windows < cfg.track_windows) begin
        perturb(v_avg, i_avg);
        stepped = 1'b1;
      end
    end
    r.duty        = DUTY_W'(duty_acc);
    r.enable_out  = 1'b1;
    r.tracked     = stepped;
    r.overvoltage = ov;
  endfunction

  always @(posedge clk) begin
    duty_result_t want;
    duty_result_t got;
    if (!rst_n) begin
      restore_defaults();
      duty_results_q.delete();
    end else begin
      // a result leaves no earlier than the cycle after its tick, so pop before push
      if (out_ch.valid && out_ch.ready) begin
        got = '{duty: out_ch.duty, enable_out: out_ch.enable_out,
                tracked: out_ch.tracked, overvoltage: out_ch.overvoltage};
        if (duty_results_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = duty_results_q.pop_front();
          if (got.duty !== want.duty)
            report_mismatch($sformatf("result %0d duty %0d, expected %0d",
                                      n_results, got.duty, want.duty));
          if (got.enable_out !== want.enable_out)
            report_mismatch($sformatf("result %0d enable_out %0b, expected %0b",
                                      n_results, got.enable_out, want.enable_out));
          if (got.tracked !== want.tracked)
            report_mismatch($sformatf("result %0d tracked %0b, expected %0b",
                                      n_results, got.tracked, want.tracked));
          if (got.overvoltage !== want.overvoltage)
            report_mismatch($sformatf("result %0d overvoltage %0b, expected %0b",
                                      n_results, got.overvoltage, want.overvoltage));
        end
        n_results++;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DUTY_MAX:       cfg.duty_max       = cfg_wdata[DUTY_W-1:0];
          CFG_MPPT_STEP:      cfg.mppt_step      = cfg_wdata[STEP_W-1:0];
          CFG_OV_LIMIT:       cfg.ov_limit       = cfg_wdata[ADC_W-1:0];
          CFG_OV_STEP:        cfg.ov_step        = cfg_wdata[STEP_W-1:0];
          CFG_MIN_INPUT:      cfg.min_input      = cfg_wdata[ADC_W-1:0];
          CFG_TRACK_WINDOWS:  cfg.track_windows  = cfg_wdata[WIN_W-1:0];
          CFG_PERIOD_WINDOWS: cfg.period_windows = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_tick(in_ch.emergency, in_ch.out_voltage, in_ch.in_voltage,
                     in_ch.in_current, want);
        duty_results_q.push_back(want);
      end
    end
    pending_cnt <= duty_results_q.size();
    fail_cnt    <= errors;
  end

endmodule

### dv/tb_mppt_perturb_observe_duty.sv
`timescale 1ns / 100ps

module tb_mppt_perturb_observe_duty;
  import mppt_pod_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          PHASE_TICKS = 130;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          fail_cnt;
  int          pending_cnt;
  int unsigned cycle_cnt = 0;

  bit               src_idle;
  bit               snk_idle;
  cfg_regs_t        cur_cfg;
  int               ticks_sent;
  logic [ADC_W-1:0] v_level;
  logic [ADC_W-1:0] i_level;

  mppt_pod_in_if  in_ch ();
  mppt_pod_out_if out_ch ();

  mppt_perturb_observe_duty dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  duty_tick_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** mppt_perturb_observe_duty: FAILED **");
      $finish;
    end
  end

  function automatic logic [ADC_W-1:0] near(input logic [ADC_W-1:0] c, input int spread);
    int x;
    x = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    return ADC_W'(x);
  endfunction

  function automatic cfg_regs_t pick_settings(input int mode);
    cfg_regs_t s;
    s.duty_max       = ($urandom_range(0, 4) == 0) ? DUTY_W'($urandom)
                                                   : DUTY_W'($urandom_range(1000, 8191));
    s.mppt_step      = STEP_W'($urandom);
    s.ov_limit       = ADC_W'($urandom);
    s.ov_step        = STEP_W'($urandom_range(0, 300));
    s.min_input      = ($urandom_range(0, 3) == 0) ? ADC_W'($urandom)
                                                   : ADC_W'($urandom_range(0, 200));
    s.track_windows  = ($urandom_range(0, 4) == 0) ? '1 : WIN_W'($urandom_range(0, 60));
    s.period_windows = ($urandom_range(0, 4) == 0) ? '1 : WIN_W'($urandom_range(1, 60));
    case (mode)
      0: s = '{duty_max: '0, mppt_step: '0, ov_limit: '0, ov_step: '0, min_input: '0,
               track_windows: '0, period_windows: 11'd1};
      1: s = '1;
      2: s = '{duty_max: RST_DUTY_MAX, mppt_step: RST_MPPT_STEP, ov_limit: RST_OV_LIMIT,
               ov_step: RST_OV_STEP, min_input: RST_MIN_INPUT,
               track_windows: RST_TRACK_WINDOWS, period_windows: RST_PERIOD_WINDOWS};
      // counter wraps on every window end, so no step is ever taken
      3: begin
        s.period_windows = '0;
        s.track_windows  = '1;
      end
      // tracking limit beyond the period: every window steps except the wrap
      4: begin
        s.period_windows = 11'd3;
        s.track_windows  = '1;
        s.min_input      = 12'd20;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_settings(input cfg_regs_t s);
    cfg_idx_t idx;
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_DUTY_MAX:       cfg_wdata <= CFG_DATA_W'(s.duty_max);
        CFG_MPPT_STEP:      cfg_wdata <= CFG_DATA_W'(s.mppt_step);
        CFG_OV_LIMIT:       cfg_wdata <= CFG_DATA_W'(s.ov_limit);
        CFG_OV_STEP:        cfg_wdata <= CFG_DATA_W'(s.ov_step);
        CFG_MIN_INPUT:      cfg_wdata <= CFG_DATA_W'(s.min_input);
        CFG_TRACK_WINDOWS:  cfg_wdata <= CFG_DATA_W'(s.track_windows);
        CFG_PERIOD_WINDOWS: cfg_wdata <= CFG_DATA_W'(s.period_windows);
        default:            cfg_wdata <= '0;
      endcase
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we  <= 1'b0;
    cur_cfg  = s;
  endtask

  task automatic send_tick(input logic emerg, input logic [ADC_W-1:0] vo,
                           input logic [ADC_W-1:0] vi, input logic [ADC_W-1:0] ii);
    int gap;
    gap = src_idle ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.emergency   <= emerg;
    in_ch.out_voltage <= vo;
    in_ch.in_voltage  <= vi;
    in_ch.in_current  <= ii;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    ticks_sent++;
  endtask

  // samples cluster around a level held for a window, so averages move between windows
  task automatic random_tick();
    int               sel;
    logic [ADC_W-1:0] vo;
    logic [ADC_W-1:0] vi;
    logic [ADC_W-1:0] ii;
    if (ticks_sent % WINDOW_TICKS == 0) begin
      v_level = ($urandom_range(0, 9) == 0) ? ADC_W'($urandom_range(0, 120))
                                            : ADC_W'($urandom);
      i_level = ADC_W'($urandom);
    end
    sel = $urandom_range(0, 9);
    if (sel < 5) vo = near(cur_cfg.ov_limit, 2);
    else if (sel == 5) vo = '0;
    else if (sel == 6) vo = '1;
    else vo = ADC_W'($urandom);
    vi = ($urandom_range(0, 4) == 0) ? ADC_W'($urandom) : near(v_level, 20);
    ii = ($urandom_range(0, 4) == 0) ? ADC_W'($urandom) : near(i_level, 20);
    send_tick(1'b0, vo, vi, ii);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (6) @(posedge clk);
  endtask

  // result side: random stalls plus a long hold-off now and then
  initial begin
    int gap;
    int rx_count;
    rx_count     = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = snk_idle ? $urandom_range(0, 17) : 0;
      if (rx_count % 1000 == 300) gap = 70;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      rx_count++;
    end
  end

  initial begin
    int phase;
    int n_rand;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_DUTY_MAX;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.emergency   <= 1'b0;
    in_ch.out_voltage <= '0;
    in_ch.in_voltage  <= '0;
    in_ch.in_current  <= '0;
    src_idle   = 1'b1;
    snk_idle   = 1'b1;
    ticks_sent = 0;
    v_level    = '0;
    i_level    = '0;
    cur_cfg    = pick_settings(2);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes and overvoltage runs under reset settings
    send_tick(1'b0, '0, '0, '0);
    send_tick(1'b0, '1, '1, '1);
    send_tick(1'b0, '1, '0, '1);
    send_tick(1'b0, '1, '1, '0);
    send_tick(1'b0, RST_OV_LIMIT, 12'hAAA, 12'h555);
    send_tick(1'b0, RST_OV_LIMIT + 1'b1, 12'h555, 12'hAAA);
    send_tick(1'b0, RST_OV_LIMIT + 1'b1, 12'hAAA, 12'h555);
    send_tick(1'b0, 12'h555, '0, '1);
    send_tick(1'b0, 12'hAAA, '1, '0);
    send_tick(1'b0, '0, '1, '1);
    wait_idle();

    phase  = 0;
    n_rand = 0;
    while (n_rand < 650) begin
      write_settings(pick_settings(phase));
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      repeat (PHASE_TICKS) random_tick();
      n_rand += PHASE_TICKS;
      wait_idle();
      phase++;
    end

    // emergency halts the block for the rest of the run
    write_settings(pick_settings(5));
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (50) random_tick();
    send_tick(1'b1, '1, ADC_W'($urandom), ADC_W'($urandom));
    repeat (30) begin
      send_tick(1'($urandom_range(0, 1)), ADC_W'($urandom), ADC_W'($urandom),
                ADC_W'($urandom));
    end
    wait_idle();
    repeat (8) @(posedge clk);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("** mppt_perturb_observe_duty: PASSED **");
    end else begin
      $display("** mppt_perturb_observe_duty: FAILED **");
    end
    $finish;
  end

endmodule

### mppt_perturb_observe_duty.f
+incdir+sv
sv/mppt_pod_pkg.sv
sv/mppt_pod_if.sv
sv/mppt_pod_cfg.sv
sv/mppt_pod_trk.sv
sv/mppt_perturb_observe_duty.sv
dv/duty_tick_checker.sv
dv/tb_mppt_perturb_observe_duty.sv
